### hw/rtl/kra_pkg.sv
package kra_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int TOP_COUNT_DEF   = 4;
    localparam int KEY_W           = 34;
    localparam int RSSI_W          = 8;
    localparam int SUM_W           = 15;
    localparam int CNT_W           = 7;
    localparam int RANK_W          = 4;
    localparam logic [CNT_W-1:0]  COUNT_MAX = 7'd127;
    localparam logic [RSSI_W-1:0] EMPTY_AVG = 8'hFF;

    typedef enum logic [0:0] {
        OP_REPORT = 1'b0,
        OP_FLUSH  = 1'b1
    } op_t;

    // one table entry as it moves along the chain
    typedef struct packed {
        logic                     valid;
        logic [KEY_W-1:0]         key;
        logic signed [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]         count;
        logic signed [RSSI_W-1:0] avg;
    } entry_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                     shift;
        logic                     report;
        logic                     clear;
        logic [KEY_W-1:0]         key;
        logic signed [RSSI_W-1:0] rssi;
    } cell_ctrl_t;

    // status a cell hands to its right neighbor
    typedef struct packed {
        logic hit;
        logic free_seen;
    } cell_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIV,
        ST_SCAN,
        ST_EMIT,
        ST_CLEAR
    } state_t;

endpackage

### hw/rtl/kra_cell.sv
module kra_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  kra_pkg::cell_ctrl_t ctrl,
    input  kra_pkg::entry_t     ent_in,
    input  kra_pkg::cell_stat_t stat_in,
    input  logic                div_load,
    input  logic signed [kra_pkg::RSSI_W-1:0] div_avg,
    output kra_pkg::entry_t     ent_out,
    output kra_pkg::cell_stat_t stat_out
);

    kra_pkg::entry_t ent_reg;
    kra_pkg::entry_t ent_next;
    logic            valid_reg;
    logic            hit;
    logic            claim;

    // match on this cell's key, or first free slot seen along the chain
    assign hit   = valid_reg && ent_reg.key == ctrl.key;
    assign claim = !valid_reg && !stat_in.free_seen && !stat_in.hit;

    assign stat_out.hit       = stat_in.hit || hit;
    assign stat_out.free_seen = stat_in.free_seen || !valid_reg;

    // entry update
    always_comb
    begin
        ent_next = ent_reg;
        ent_next.valid = valid_reg;
        if (ctrl.shift)
        begin
            ent_next = ent_in;
        end
        else if (div_load)
        begin
            ent_next.avg = div_avg;
        end
        else if (ctrl.clear)
        begin
            ent_next.valid = 1'b0;
        end
        else if (ctrl.report && hit && ent_reg.count != kra_pkg::COUNT_MAX)
        begin
            ent_next.count = ent_reg.count + 1'b1;
            ent_next.sum   = ent_reg.sum + kra_pkg::SUM_W'(ctrl.rssi);
        end
        else if (ctrl.report && claim)
        begin
            ent_next.valid = 1'b1;
            ent_next.key   = ctrl.key;
            ent_next.sum   = kra_pkg::SUM_W'(ctrl.rssi);
            ent_next.count = 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ent_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_comb
    begin
        ent_out = ent_reg;
        ent_out.valid = valid_reg;
    end

endmodule

### hw/rtl/kra_div.sv
module kra_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [kra_pkg::SUM_W-1:0]  sum,
    input  logic [kra_pkg::CNT_W-1:0]         count,
    output logic                              done,
    output logic signed [kra_pkg::RSSI_W-1:0] quot
);

    localparam int SW = kra_pkg::SUM_W;
    localparam int CW = kra_pkg::CNT_W;
    localparam int NW = $clog2(SW + 1);

    logic [SW-1:0] num_reg, num_next;
    logic [CW:0]   rem_reg, rem_next;
    logic [CW-1:0] den_reg;
    logic          neg_reg;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [CW:0]   trial;
    logic [SW-1:0] mag;
    logic [SW-1:0] q_signed;

    assign mag   = sum[SW-1] ? SW'(-sum) : sum;
    assign trial = {rem_reg[CW-1:0], num_reg[SW-1]};

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            num_next  = mag;
            rem_next  = '0;
            cnt_next  = NW'(SW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                num_next = {num_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                num_next = {num_reg[SW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == NW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= (count == '0) ? CW'(1) : count;
            neg_reg <= sum[SW-1];
        end
    end

    assign done     = busy_reg && cnt_reg == NW'(1);
    assign q_signed = neg_reg ? SW'(-num_next) : num_next;
    assign quot     = q_signed[kra_pkg::RSSI_W-1:0];

endmodule

### hw/rtl/keyed_rssi_average_top_select_core.sv
// Keyed RSSI averaging table built as a ring of TABLE_DEPTH cells. A report
// (op 0) is compared against every cell at once: a matching entry adds the RSSI
// and counts up to 127, otherwise the lowest free cell opens a new entry, and a
// new key on a full table is dropped; a report passes through a walk state
// before the block takes the next item. A flush (op 1) first rotates the
// ring once, stopping at each valid entry while a bit-serial divider works
// out its average, then rotates the ring once per rank to find the best entry
// (ties go to the higher slot, the previous pick is dropped on the way), emits
// TOP_COUNT results best first, and clears the table. A flush on an empty table
// gives no results. Results are held in one output register, so a stalled
// receiver holds up the flush; the block takes a new item once a flush is done.
module keyed_rssi_average_top_select_core #(
    parameter int TABLE_DEPTH = kra_pkg::TABLE_DEPTH_DEF,
    parameter int TOP_COUNT   = kra_pkg::TOP_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: student_key[33:0], rssi[41:34], zero fill
    input  logic [47:0] s_tdata,
    // tuser: op
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: rank[3:0], student_key_res[37:4], avg_rssi[45:38], empty_res[46], zero fill
    output logic [47:0] m_tdata,
    output logic        m_tlast
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int RW = kra_pkg::RANK_W;

    kra_pkg::state_t    state_reg, state_next;
    kra_pkg::cell_ctrl_t ctrl;
    kra_pkg::entry_t    ent_out [TABLE_DEPTH];
    kra_pkg::cell_stat_t stat   [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] div_load;

    logic [IW:0]  step_reg, step_next;
    logic [RW-1:0] rank_reg, rank_next;
    logic [kra_pkg::KEY_W-1:0]  key_reg;
    logic signed [kra_pkg::RSSI_W-1:0] rssi_reg;
    logic         any_reg, any_next;
    logic         best_ok_reg, best_ok_next;
    logic signed [kra_pkg::RSSI_W-1:0] best_avg_reg, best_avg_next;
    logic [IW-1:0] best_pos_reg, best_pos_next;
    logic [kra_pkg::KEY_W-1:0] best_key_reg, best_key_next;
    logic         drop_ok_reg, drop_ok_next;
    logic [IW-1:0] drop_pos_reg, drop_pos_next;
    logic         div_run_reg, div_run_next;
    logic         div_ld_reg, div_ld_next;
    logic         div_start;
    logic         div_done;
    logic signed [kra_pkg::RSSI_W-1:0] div_quot;
    logic         out_valid_reg, out_valid_next;
    logic [47:0]  out_data_reg, out_data_next;
    logic         out_last_reg, out_last_next;
    logic         s_fire;
    logic         kill;
    kra_pkg::entry_t head;

    assign s_fire = s_tvalid && s_tready;
    assign head   = ent_out[TABLE_DEPTH-1];

    // ring of cells; the head is cell TABLE_DEPTH-1, it wraps into cell 0
    assign stat[0] = '0;
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            kra_pkg::entry_t cin;
            kra_pkg::cell_ctrl_t cc;
            always_comb
            begin
                cin = (g == 0) ? head : ent_out[(g == 0) ? 0 : g-1];
                cc  = ctrl;
                if (g == 0 && kill)
                begin
                    cin.valid = 1'b0;
                end
                // report compare happens once, as the report is accepted; the ring does not rotate for it
                cc.report = ctrl.report;
            end
            kra_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cc),
                .ent_in   (cin),
                .stat_in  (stat[g]),
                .div_load (div_load[g]),
                .div_avg  (div_quot),
                .ent_out  (ent_out[g]),
                .stat_out (stat[g+1])
            );
        end
    endgenerate

    kra_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (head.sum),
        .count (head.count),
        .done  (div_done),
        .quot  (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kra_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = (s_tuser == kra_pkg::OP_FLUSH) ? kra_pkg::ST_DIV
                                                                : kra_pkg::ST_WALK;
                end
            end
            kra_pkg::ST_WALK:
            begin
                if (step_reg == (IW+1)'(TABLE_DEPTH))
                begin
                    state_next = kra_pkg::ST_IDLE;
                end
            end
            kra_pkg::ST_DIV:
            begin
                if (step_reg == (IW+1)'(TABLE_DEPTH))
                begin
                    state_next = any_reg ? kra_pkg::ST_SCAN : kra_pkg::ST_IDLE;
                end
            end
            kra_pkg::ST_SCAN:
            begin
                if (step_reg == (IW+1)'(TABLE_DEPTH))
                begin
                    state_next = kra_pkg::ST_EMIT;
                end
            end
            kra_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = (rank_reg == RW'(TOP_COUNT-1)) ? kra_pkg::ST_CLEAR
                                                                : kra_pkg::ST_SCAN;
                end
            end
            kra_pkg::ST_CLEAR:
            begin
                state_next = kra_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = kra_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs and datapath
    always_comb
    begin
        ctrl.shift  = 1'b0;
        ctrl.report = 1'b0;
        ctrl.clear  = 1'b0;
        ctrl.key    = key_reg;
        ctrl.rssi   = rssi_reg;
        div_load    = '0;
        div_start   = 1'b0;
        kill        = 1'b0;
        step_next   = step_reg;
        rank_next   = rank_reg;
        any_next    = any_reg;
        best_ok_next  = best_ok_reg;
        best_avg_next = best_avg_reg;
        best_pos_next = best_pos_reg;
        best_key_next = best_key_reg;
        drop_ok_next  = drop_ok_reg;
        drop_pos_next = drop_pos_reg;
        div_run_next  = div_run_reg;
        div_ld_next   = div_ld_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        s_tready = 1'b0;
        unique case (state_reg)
            kra_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                step_next = '0;
                rank_next = '0;
                any_next  = 1'b0;
                best_ok_next = 1'b0;
                drop_ok_next = 1'b0;
                div_run_next = 1'b0;
                div_ld_next  = 1'b0;
                if (s_fire && s_tuser == kra_pkg::OP_REPORT)
                begin
                    // the chain does compare and insert in one pass
                    ctrl.key    = s_tdata[kra_pkg::KEY_W-1:0];
                    ctrl.rssi   = s_tdata[kra_pkg::KEY_W +: kra_pkg::RSSI_W];
                    ctrl.report = 1'b1;
                    step_next   = (IW+1)'(TABLE_DEPTH);
                end
            end
            kra_pkg::ST_WALK:
            begin
                step_next = '0;
            end
            kra_pkg::ST_DIV:
            begin
                if (step_reg != (IW+1)'(TABLE_DEPTH))
                begin
                    if (!head.valid || div_ld_reg)
                    begin
                        // head is free or has its average: move on
                        ctrl.shift   = 1'b1;
                        step_next    = step_reg + 1'b1;
                        div_run_next = 1'b0;
                        div_ld_next  = 1'b0;
                    end
                    else if (!div_run_reg)
                    begin
                        div_start    = 1'b1;
                        div_run_next = 1'b1;
                    end
                    else if (div_done)
                    begin
                        div_load[TABLE_DEPTH-1] = 1'b1;
                        div_ld_next = 1'b1;
                        any_next    = 1'b1;
                    end
                end
                else
                begin
                    step_next = '0;
                end
            end
            kra_pkg::ST_SCAN:
            begin
                if (step_reg != (IW+1)'(TABLE_DEPTH))
                begin
                    ctrl.shift = 1'b1;
                    step_next  = step_reg + 1'b1;
                    // step 0 sees slot TABLE_DEPTH-1; later steps lower slots,
                    // so >= would favor low slots: use > to keep the high one
                    if (drop_ok_reg && step_reg[IW-1:0] == drop_pos_reg)
                    begin
                        // previous rank's pick leaves the table as it wraps
                        kill = 1'b1;
                    end
                    else if (head.valid && (!best_ok_reg || head.avg > best_avg_reg))
                    begin
                        best_ok_next  = 1'b1;
                        best_avg_next = head.avg;
                        best_pos_next = step_reg[IW-1:0];
                        best_key_next = head.key;
                    end
                end
            end
            kra_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = rank_reg == RW'(TOP_COUNT-1);
                    out_data_next  = '0;
                    out_data_next[RW-1:0] = rank_reg;
                    if (best_ok_reg)
                    begin
                        out_data_next[RW +: kra_pkg::KEY_W]    = best_key_reg;
                        out_data_next[RW+kra_pkg::KEY_W +: 8]  = best_avg_reg;
                    end
                    else
                    begin
                        out_data_next[RW+kra_pkg::KEY_W +: 8]  = kra_pkg::EMPTY_AVG;
                        out_data_next[RW+kra_pkg::KEY_W+8]     = 1'b1;
                    end
                    drop_ok_next  = best_ok_reg;
                    drop_pos_next = best_pos_reg;
                    rank_next    = rank_reg + 1'b1;
                    step_next    = '0;
                    best_ok_next = 1'b0;
                end
            end
            kra_pkg::ST_CLEAR:
            begin
                ctrl.clear = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kra_pkg::ST_IDLE;
            step_reg      <= '0;
            rank_reg      <= '0;
            any_reg       <= 1'b0;
            best_ok_reg   <= 1'b0;
            drop_ok_reg   <= 1'b0;
            div_run_reg   <= 1'b0;
            div_ld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rank_reg      <= rank_next;
            any_reg       <= any_next;
            best_ok_reg   <= best_ok_next;
            drop_ok_reg   <= drop_ok_next;
            div_run_reg   <= div_run_next;
            div_ld_reg    <= div_ld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_avg_reg <= best_avg_next;
        best_pos_reg <= best_pos_next;
        best_key_reg <= best_key_next;
        drop_pos_reg <= drop_pos_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        if (s_fire)
        begin
            key_reg  <= s_tdata[kra_pkg::KEY_W-1:0];
            rssi_reg <= s_tdata[kra_pkg::KEY_W +: kra_pkg::RSSI_W];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

### tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = kra_pkg::TABLE_DEPTH_DEF;
    localparam int TOPN  = kra_pkg::TOP_COUNT_DEF;

    typedef struct packed {
        logic [kra_pkg::RANK_W-1:0]        rank;
        logic [kra_pkg::KEY_W-1:0]         key;
        logic signed [kra_pkg::RSSI_W-1:0] avg;
        logic                              empty;
        logic                              last;
    } ranked_t;

    typedef struct {
        kra_pkg::op_t                      op;
        logic [kra_pkg::KEY_W-1:0]         key;
        logic signed [kra_pkg::RSSI_W-1:0] rssi;
        bit                                typed;
        ranked_t                           want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;

    // tracked copy of the table
    bit                        tbl_valid [DEPTH];
    logic [kra_pkg::KEY_W-1:0] tbl_key   [DEPTH];
    int                        tbl_sum   [DEPTH];
    int                        tbl_count [DEPTH];

    ranked_t   ranked_q[$];
    bit        typed_q[$];
    ranked_t   typed_want_q[$];
    stim_row_t rows[$];
    int        errors;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_off;
    bit        press_go;

    keyed_rssi_average_top_select_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // update the table copy and queue the ranked entries a flush yields
    task automatic predict_rank(input kra_pkg::op_t op,
                                input logic [kra_pkg::KEY_W-1:0] key,
                                input logic signed [kra_pkg::RSSI_W-1:0] rssi);
        int  free_slot;
        int  best;
        int  best_avg;
        int  a;
        bit  any;
        ranked_t r;
        free_slot = -1;
        any = 0;
        if (op == kra_pkg::OP_REPORT)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (tbl_valid[i])
                begin
                    if (tbl_key[i] == key)
                    begin
                        if (tbl_count[i] < int'(kra_pkg::COUNT_MAX))
                        begin
                            tbl_count[i]++;
                            tbl_sum[i] += int'(rssi);
                        end
                        return;
                    end
                end
                else if (free_slot < 0)
                    free_slot = i;
            end
            if (free_slot >= 0)
            begin
                tbl_valid[free_slot] = 1;
                tbl_key[free_slot]   = key;
                tbl_sum[free_slot]   = int'(rssi);
                tbl_count[free_slot] = 1;
            end
            return;
        end
        foreach (tbl_valid[i])
            if (tbl_valid[i])
                any = 1;
        if (!any)
            return;
        for (int k = 0; k < TOPN; k++)
        begin
            best = -1;
            best_avg = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (tbl_valid[i])
                begin
                    a = tbl_sum[i] / tbl_count[i];
                    if (best < 0 || a >= best_avg)
                    begin
                        best = i;
                        best_avg = a;
                    end
                end
            end
            r.rank = kra_pkg::RANK_W'(k);
            r.last = (k == TOPN - 1);
            if (best >= 0)
            begin
                r.key   = tbl_key[best];
                r.avg   = kra_pkg::RSSI_W'(best_avg);
                r.empty = 0;
                tbl_valid[best] = 0;
            end
            else
            begin
                r.key   = '0;
                r.avg   = kra_pkg::EMPTY_AVG;
                r.empty = 1;
            end
            ranked_q.push_back(r);
            typed_q.push_back(0);
        end
        foreach (tbl_valid[i])
            tbl_valid[i] = 0;
    endtask

    // offer one transfer and wait for acceptance
    task automatic send_item(input kra_pkg::op_t op,
                             input logic [kra_pkg::KEY_W-1:0] key,
                             input logic signed [kra_pkg::RSSI_W-1:0] rssi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, rssi, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_rank(op, key, rssi);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 0;
        while (ranked_q.size() != 0)
            @(negedge clk);
        repeat (DEPTH * 20) @(negedge clk);
    endtask

    // receiver backpressure
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            m_tready <= 0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        ranked_t got;
        ranked_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[3:0], m_tdata[37:4], m_tdata[45:38], m_tdata[46], m_tlast};
            if (ranked_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
            end
            else
            begin
                want = ranked_q.pop_front();
                if (typed_q.pop_front())
                    want = typed_want_q.pop_front();
                if (got.rank !== want.rank || got.key !== want.key
                    || got.avg !== want.avg || got.empty !== want.empty
                    || got.last !== want.last)
                begin
                    $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
                    errors++;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up on its input
    initial
    begin
        hold_off = 0;
        wait (press_go);
        @(negedge clk);
        hold_off <= 1;
        repeat (1500) @(negedge clk);
        hold_off <= 0;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic stim_row_t mk(kra_pkg::op_t op, logic [kra_pkg::KEY_W-1:0] key,
                                     logic signed [kra_pkg::RSSI_W-1:0] rssi);
        stim_row_t s;
        s.op = op;
        s.key = key;
        s.rssi = rssi;
        s.typed = 0;
        s.want = '0;
        return s;
    endfunction

    initial
    begin
        logic [kra_pkg::KEY_W-1:0] pool [8];
        stim_row_t s;
        int n;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        errors = 0;
        send_idle_pct = 13;
        recv_idle_pct = 79;
        foreach (tbl_valid[i])
            tbl_valid[i] = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed rows: empty flush, extremes, ties, short table
        rows.push_back(mk(kra_pkg::OP_FLUSH, '0, 0));
        rows.push_back(mk(kra_pkg::OP_REPORT, '1, 8'sd127));
        rows.push_back(mk(kra_pkg::OP_REPORT, '0, 8'sh80));
        rows.push_back(mk(kra_pkg::OP_REPORT, 34'd9999999999, -8'sd5));
        rows.push_back(mk(kra_pkg::OP_REPORT, 34'd9999999999, 8'sd2));
        rows.push_back(mk(kra_pkg::OP_REPORT, 34'h155555555, -8'sd2));
        s = mk(kra_pkg::OP_FLUSH, '0, 0);
        s.typed = 1;
        s.want = {4'd0, 34'h3FFFFFFFF, 8'sd127, 1'b0, 1'b0};
        rows.push_back(s);
        rows.push_back(mk(kra_pkg::OP_REPORT, 34'd5, 8'sd10));
        rows.push_back(mk(kra_pkg::OP_REPORT, 34'd6, 8'sd10));
        rows.push_back(mk(kra_pkg::OP_FLUSH, '0, 0));
        foreach (rows[i])
        begin
            if (rows[i].typed)
            begin
                send_item(rows[i].op, rows[i].key, rows[i].rssi);
                typed_q[typed_q.size() - TOPN] = 1;
                typed_want_q.push_back(rows[i].want);
            end
            else
                send_item(rows[i].op, rows[i].key, rows[i].rssi);
        end

        // full table: one more distinct key than slots
        for (int i = 0; i < DEPTH + 1; i++)
            send_item(kra_pkg::OP_REPORT, kra_pkg::KEY_W'(1000 + i),
                      kra_pkg::RSSI_W'($urandom));
        send_item(kra_pkg::OP_FLUSH, '0, 0);
        drain_results();

        // random phases over three idling profiles
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 79 : 0;
            recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 13 : 0;
            if (ph == 0)
                press_go = 1;
            for (int j = 0; j < 8; j++)
                pool[j] = kra_pkg::KEY_W'({$urandom, $urandom});
            n = 0;
            while (n < 24)
            begin
                if ($urandom_range(9) == 0 || (ph == 0 && n == 1))
                    send_item(kra_pkg::OP_FLUSH, kra_pkg::KEY_W'({$urandom, $urandom}),
                              kra_pkg::RSSI_W'($urandom));
                else if ($urandom_range(3) == 0)
                    send_item(kra_pkg::OP_REPORT, kra_pkg::KEY_W'({$urandom, $urandom}),
                              kra_pkg::RSSI_W'($urandom));
                else
                    send_item(kra_pkg::OP_REPORT, pool[$urandom_range(7)],
                              kra_pkg::RSSI_W'($urandom));
                n++;
            end
            send_item(kra_pkg::OP_FLUSH, '0, 0);
            drain_results();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

### sim.f
hw/rtl/kra_pkg.sv
hw/rtl/kra_cell.sv
hw/rtl/kra_div.sv
hw/rtl/keyed_rssi_average_top_select_core.sv
tb/sv/testbench.sv
